// ----- hw/rtl/pixel_colorspace_converter_defines.svh -----
// Assertion macros for the pixel color space converter.
// Used by the top level; expects clk and rst in scope.
`ifndef PIXEL_COLORSPACE_CONVERTER_DEFINES_SVH
`define PIXEL_COLORSPACE_CONVERTER_DEFINES_SVH

// The condition must never hold outside reset.
`define PCC_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define PCC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hw/rtl/pcc_pkg.sv -----
// Shared types and constants for the pixel color space converter.
// No dependencies.
package pcc_pkg;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [1:0] SPACE_RGB = 2'd0;
  localparam logic [1:0] SPACE_HSV = 2'd1;
  localparam logic [1:0] SPACE_YUV = 2'd2;

  localparam logic [1:0] REG_SOURCE = 2'd0;
  localparam logic [1:0] REG_TARGET = 2'd1;

  typedef enum logic [2:0] {
    OP_PASS,
    OP_RGB_HSV,
    OP_RGB_YUV,
    OP_HSV_RGB,
    OP_HSV_YUV,
    OP_YUV_RGB,
    OP_YUV_HSV
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] c;
    logic [7:0] b;
    logic [7:0] a;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ----- hw/rtl/pcc_front.sv -----
// Front end: configuration registers, input acceptance and conversion classification.
// Depends on pcc_pkg.
module pcc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [23:0]         s_tdata,    // comp_a, comp_b, comp_c
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [1:0]          cfg_data,
  input  pcc_pkg::queue_stat_t q_stat,
  output logic                push,
  output pcc_pkg::item_t      push_item
);
  import pcc_pkg::*;

  logic [1:0] source_space;
  logic [1:0] target_space;
  op_t        op;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_space <= SPACE_RGB;
      target_space <= SPACE_HSV;
    end else if (cfg_valid) begin
      if (cfg_index == REG_SOURCE) begin
        source_space <= cfg_data;
      end else if (cfg_index == REG_TARGET) begin
        target_space <= cfg_data;
      end
    end
  end

  always_comb begin
    unique case ({source_space, target_space})
      {SPACE_RGB, SPACE_HSV}: op = OP_RGB_HSV;
      {SPACE_RGB, SPACE_YUV}: op = OP_RGB_YUV;
      {SPACE_HSV, SPACE_RGB}: op = OP_HSV_RGB;
      {SPACE_HSV, SPACE_YUV}: op = OP_HSV_YUV;
      {SPACE_YUV, SPACE_RGB}: op = OP_YUV_RGB;
      {SPACE_YUV, SPACE_HSV}: op = OP_YUV_HSV;
      default:                op = OP_PASS;
    endcase
  end

  assign s_tready = !q_stat.full;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    push_item.op = op;
    push_item.a  = s_tdata[7:0];
    push_item.b  = s_tdata[15:8];
    push_item.c  = s_tdata[23:16];
  end

endmodule

// ----- hw/rtl/pcc_queue.sv -----
// Short queue between the front end and the conversion pipeline.
// Depends on pcc_pkg.
module pcc_queue #(
  parameter int unsigned DEPTH = pcc_pkg::FIFO_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  pcc_pkg::item_t       push_item,
  input  logic                 pop,
  output pcc_pkg::item_t       head,
  output pcc_pkg::queue_stat_t q_stat
);
  import pcc_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t          mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head         = mem[rd_ptr];
  assign q_stat.full  = (count == CW'(DEPTH));
  assign q_stat.empty = (count == '0);

endmodule

// ----- hw/rtl/pcc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, several lanes and a payload.
// No dependencies.
module pcc_div #(
  parameter int unsigned LANES = 1,
  parameter int unsigned NW    = 16,
  parameter int unsigned DW    = 8,
  parameter int unsigned QW    = 8,
  parameter int unsigned PW    = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vld_i,
  input  logic [NW-1:0] num [LANES],
  input  logic [DW-1:0] den [LANES],
  input  logic [PW-1:0] pay_i,
  output logic          vld_o,
  output logic [QW-1:0] quo [LANES],
  output logic [PW-1:0] pay_o
);
  // The quotient must be known to fit in QW bits.
  localparam int unsigned WW = (NW > DW + QW) ? NW : DW + QW;

  logic [WW-1:0] rem_r [QW-1][LANES];
  logic [DW-1:0] den_r [QW-1][LANES];
  logic [QW-1:0] quo_r [QW][LANES];
  logic [PW-1:0] pay_r [QW];
  logic [QW-1:0] vld_r;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [WW-1:0] r_in;
      logic [WW-1:0] trial;
      logic [DW-1:0] d_in;
      logic [QW-1:0] q_in;
      logic          ge;

      if (i == 0) begin : g_first
        assign r_in = WW'(num[l]);
        assign d_in = den[l];
        assign q_in = '0;
      end else begin : g_rest
        assign r_in = rem_r[i-1][l];
        assign d_in = den_r[i-1][l];
        assign q_in = quo_r[i-1][l];
      end

      assign trial = WW'(d_in) << (QW - 1 - i);
      assign ge    = (r_in >= trial);

      always_ff @(posedge clk) begin
        if (en) begin
          quo_r[i][l] <= q_in | (QW'(ge) << (QW - 1 - i));
        end
      end

      if (i < QW - 1) begin : g_keep
        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[i][l] <= ge ? r_in - trial : r_in;
            den_r[i][l] <= d_in;
          end
        end
      end
    end

    if (i == 0) begin : g_pay_first
      always_ff @(posedge clk) begin
        if (en) begin
          pay_r[i] <= pay_i;
        end
      end
    end else begin : g_pay_rest
      always_ff @(posedge clk) begin
        if (en) begin
          pay_r[i] <= pay_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QW-2:0], vld_i};
    end
  end

  assign vld_o = vld_r[QW-1];
  assign pay_o = pay_r[QW-1];
  assign quo   = quo_r[QW-1];

endmodule

// ----- hw/rtl/pcc_back.sv -----
// Back end: conversion pipeline from the queue head to the output register.
// Depends on pcc_pkg and pcc_div.
module pcc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  pcc_pkg::item_t       head,
  input  pcc_pkg::queue_stat_t q_stat,
  output logic                 pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,   // res_a, res_b, res_c
  output logic                 m_tuser    // converted
);
  import pcc_pkg::*;

  localparam logic signed [29:0] K_UB    = 30'sd1858076;
  localparam logic signed [29:0] K_UG    = 30'sd360857;
  localparam logic signed [29:0] K_VG    = 30'sd748830;
  localparam logic signed [29:0] K_VR    = 30'sd1470103;
  localparam logic signed [30:0] ROUND20 = 31'sd524288;

  typedef struct packed {
    op_t        op;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] yr;
    logic [7:0] yg;
    logic [7:0] yb;
    logic [2:0] sec;
    logic       sat_zero;
  } d1_pay_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] mr;
    logic [7:0] mg;
    logic [7:0] mb;
    logic [7:0] mx;
    logic       gray;
    logic       neg;
    logic [7:0] base;
    logic [7:0] yy;
    logic [7:0] yu;
    logic [7:0] yv;
  } d2_pay_t;

  function automatic logic [7:0] clamp20(input logic signed [30:0] s);
    logic [10:0] q;
    q = s[30:20];
    if (s < 0) begin
      return 8'd0;
    end else if (q > 11'd255) begin
      return 8'd255;
    end
    return q[7:0];
  endfunction

  function automatic logic [7:0] clamp13(input logic signed [22:0] s, input logic [7:0] lim);
    logic [9:0] q;
    q = s[22:13];
    if (s < 0) begin
      return 8'd0;
    end else if (q > 10'(lim)) begin
      return lim;
    end
    return q[7:0];
  endfunction

  logic adv;
  assign adv = !m_tvalid || m_tready;
  assign pop = adv && !q_stat.empty;

  // Stage 1: hue sector split, saturation products, chroma products.
  logic [10:0] t6;
  logic [2:0]  sec;
  logic [7:0]  frac;
  logic signed [8:0]  u_c;
  logic signed [8:0]  v_c;
  logic signed [29:0] u_e;
  logic signed [29:0] v_e;

  always_comb begin
    t6  = 11'(head.a) * 11'd6;
    sec = '0;
    for (int k = 1; k <= 5; k++) begin
      if (t6 >= 11'(255 * k)) begin
        sec = sec + 3'd1;
      end
    end
    frac = 8'(t6 - 11'(sec) * 11'd255);
    // A hue of 255 wraps to the start of sector zero.
    if (head.a == 8'd255) begin
      sec  = '0;
      frac = '0;
    end
    u_c = $signed({1'b0, head.b}) - 9'sd128;
    v_c = $signed({1'b0, head.c}) - 9'sd128;
    u_e = 30'(u_c);
    v_e = 30'(v_c);
  end

  logic        s1_v;
  op_t         s1_op;
  logic [7:0]  s1_a, s1_b, s1_c;
  logic [2:0]  s1_sec;
  logic [15:0] s1_sf, s1_sg, s1_nx;
  logic signed [29:0] s1_pb, s1_pg1, s1_pg2, s1_pr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= !q_stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op  <= head.op;
      s1_a   <= head.a;
      s1_b   <= head.b;
      s1_c   <= head.c;
      s1_sec <= sec;
      s1_sf  <= 16'(head.b) * 16'(frac);
      s1_sg  <= 16'(head.b) * 16'(8'd255 - frac);
      s1_nx  <= 16'(head.c) * 16'(8'd255 - head.b);
      s1_pb  <= u_e * K_UB;
      s1_pg1 <= u_e * K_UG;
      s1_pg2 <= v_e * K_VG;
      s1_pr  <= v_e * K_VR;
    end
  end

  // Stage 2: value products for the rounded ratios, chroma sums with clamp.
  logic signed [30:0] y20;
  assign y20 = $signed({3'b000, s1_a, 20'd0});

  logic        s2_v;
  logic [15:0] s2_nx;
  logic [23:0] s2_ny, s2_nz;
  d1_pay_t     s2_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_nx           <= s1_nx;
      s2_ny           <= 24'(s1_c) * 24'(16'd65025 - s1_sf);
      s2_nz           <= 24'(s1_c) * 24'(16'd65025 - s1_sg);
      s2_pay.op       <= s1_op;
      s2_pay.a        <= s1_a;
      s2_pay.b        <= s1_b;
      s2_pay.c        <= s1_c;
      s2_pay.sec      <= s1_sec;
      s2_pay.sat_zero <= (s1_b == 8'd0);
      s2_pay.yb       <= clamp20(y20 + 31'(s1_pb) + ROUND20);
      s2_pay.yg       <= clamp20(y20 - 31'(s1_pg1) - 31'(s1_pg2) + ROUND20);
      s2_pay.yr       <= clamp20(y20 + 31'(s1_pr) + ROUND20);
    end
  end

  // Rounded ratios: (2n + d) / (2d) for d = 255 and d = 65025, which equals
  // (n + (d - 1) / 2) / d. Each quotient comes from one reciprocal multiply
  // that is exact over the whole numerator range.
  localparam logic [16:0] RECIP_255   = 17'd65794;     // ceil(2^24 / 255)
  localparam logic [24:0] RECIP_65025 = 25'd16909061;  // ceil(2^40 / 65025)

  logic [16:0] rx_num;
  logic [23:0] ry_num, rz_num;
  logic [33:0] rx_prod;
  logic [48:0] ry_prod, rz_prod;
  logic [7:0]  d1_quo [3];
  logic        d1_vld;
  d1_pay_t     d1_pay;

  assign rx_num  = 17'(s2_nx) + 17'd127;
  assign ry_num  = s2_ny + 24'd32512;
  assign rz_num  = s2_nz + 24'd32512;
  assign rx_prod = 34'(rx_num) * 34'(RECIP_255);
  assign ry_prod = 49'(ry_num) * 49'(RECIP_65025);
  assign rz_prod = 49'(rz_num) * 49'(RECIP_65025);

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_vld <= 1'b0;
    end else if (adv) begin
      d1_vld <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_quo[0] <= rx_prod[31:24];
      d1_quo[1] <= ry_prod[47:40];
      d1_quo[2] <= rz_prod[47:40];
      d1_pay    <= s2_pay;
    end
  end

  // Intermediate RGB: raw input, HSV result or YUV result.
  logic [7:0] hr, hg, hb, vv, px, py, pz;
  logic [7:0] mid_r, mid_g, mid_b;

  always_comb begin
    vv = d1_pay.c;
    px = d1_quo[0];
    py = d1_quo[1];
    pz = d1_quo[2];
    case (d1_pay.sec)
      3'd0:    begin hr = vv; hg = pz; hb = px; end
      3'd1:    begin hr = py; hg = vv; hb = px; end
      3'd2:    begin hr = px; hg = vv; hb = pz; end
      3'd3:    begin hr = px; hg = py; hb = vv; end
      3'd4:    begin hr = pz; hg = px; hb = vv; end
      default: begin hr = vv; hg = px; hb = py; end
    endcase
    if (d1_pay.sat_zero) begin
      hr = vv;
      hg = vv;
      hb = vv;
    end
    unique case (d1_pay.op) inside
      OP_HSV_RGB, OP_HSV_YUV: begin mid_r = hr; mid_g = hg; mid_b = hb; end
      OP_YUV_RGB, OP_YUV_HSV: begin
        mid_r = d1_pay.yr;
        mid_g = d1_pay.yg;
        mid_b = d1_pay.yb;
      end
      default: begin mid_r = d1_pay.a; mid_g = d1_pay.b; mid_b = d1_pay.c; end
    endcase
  end

  logic       m1_v;
  op_t        m1_op;
  logic [7:0] m1_r, m1_g, m1_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
    end else if (adv) begin
      m1_v <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_op <= d1_pay.op;
      m1_r  <= mid_r;
      m1_g  <= mid_g;
      m1_b  <= mid_b;
    end
  end

  // Stage M2: max, min, hue sector numerator, and the YUV sums.
  logic [7:0]  mx, mn, base, mag;
  logic signed [8:0]  hn;
  logic signed [22:0] rs, gs, bs, ysum, usum, vsum;

  always_comb begin
    mx = (m1_r > m1_g) ? m1_r : m1_g;
    mn = (m1_r < m1_g) ? m1_r : m1_g;
    if (m1_b > mx) begin
      mx = m1_b;
    end
    if (m1_b < mn) begin
      mn = m1_b;
    end
    if (m1_r == mx) begin
      base = 8'd0;
      hn   = $signed({1'b0, m1_g}) - $signed({1'b0, m1_b});
    end else if (m1_g == mx) begin
      base = 8'd85;
      hn   = $signed({1'b0, m1_b}) - $signed({1'b0, m1_r});
    end else begin
      base = 8'd170;
      hn   = $signed({1'b0, m1_r}) - $signed({1'b0, m1_g});
    end
    mag  = hn[8] ? 8'(-hn) : hn[7:0];
    rs   = $signed({15'd0, m1_r});
    gs   = $signed({15'd0, m1_g});
    bs   = $signed({15'd0, m1_b});
    ysum = rs * 23'sd2104 + gs * 23'sd4130 + bs * 23'sd802 + 23'sd135168;
    usum = bs * 23'sd3598 - rs * 23'sd1214 - gs * 23'sd2384 + 23'sd1052672;
    vsum = rs * 23'sd3598 - gs * 23'sd3013 - bs * 23'sd585 + 23'sd1052672;
  end

  logic       m2_v;
  logic [7:0] m2_delta, m2_mag;
  d2_pay_t    m2_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_v <= 1'b0;
    end else if (adv) begin
      m2_v <= m1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_delta    <= mx - mn;
      m2_mag      <= mag;
      m2_pay.op   <= m1_op;
      m2_pay.mr   <= m1_r;
      m2_pay.mg   <= m1_g;
      m2_pay.mb   <= m1_b;
      m2_pay.mx   <= mx;
      m2_pay.gray <= (mx == mn);
      m2_pay.neg  <= hn[8];
      m2_pay.base <= base;
      m2_pay.yy   <= clamp13(ysum, 8'd235);
      m2_pay.yu   <= clamp13(usum, 8'd240);
      m2_pay.yv   <= clamp13(vsum, 8'd240);
    end
  end

  // Saturation 255*delta/max and hue offset 43*|diff|/delta.
  logic [15:0] d2_num [2];
  logic [7:0]  d2_den [2];
  logic [7:0]  d2_quo [2];
  logic        d2_vld;
  d2_pay_t     d2_pay;

  assign d2_num[0] = 16'(m2_delta) * 16'd255;
  assign d2_num[1] = 16'(m2_mag) * 16'd43;
  assign d2_den[0] = m2_pay.mx;
  assign d2_den[1] = m2_delta;

  pcc_div #(
    .LANES (2),
    .NW    (16),
    .DW    (8),
    .QW    (8),
    .PW    ($bits(d2_pay_t))
  ) u_div_rgb (
    .clk   (clk),
    .rst   (rst),
    .en    (adv),
    .vld_i (m2_v),
    .num   (d2_num),
    .den   (d2_den),
    .pay_i (m2_pay),
    .vld_o (d2_vld),
    .quo   (d2_quo),
    .pay_o (d2_pay)
  );

  logic [7:0] hue, sat;
  logic [23:0] res;

  always_comb begin
    hue = d2_pay.neg ? d2_pay.base - d2_quo[1] : d2_pay.base + d2_quo[1];
    sat = d2_quo[0];
    // Gray and black pixels have no hue and no saturation.
    if (d2_pay.gray) begin
      hue = 8'd0;
      sat = 8'd0;
    end
    unique case (d2_pay.op) inside
      OP_RGB_HSV, OP_YUV_HSV: res = {d2_pay.mx, sat, hue};
      OP_RGB_YUV, OP_HSV_YUV: res = {d2_pay.yv, d2_pay.yu, d2_pay.yy};
      default:                res = {d2_pay.mb, d2_pay.mg, d2_pay.mr};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && d2_vld) begin
      m_tdata <= res;
      m_tuser <= (d2_pay.op != OP_PASS);
    end
  end

endmodule

// ----- hw/rtl/pixel_colorspace_converter.sv -----
// Pixel color space converter between RGB, HSV and YUV, one pixel per clock.
// A word passes the queue, stages 1 and 2, the reciprocal divide, stages M1 and M2,
// the 8-stage saturation and hue divider and the output register.
// Throughput is one word per cycle; a stalled output holds the whole pipeline.
// Synchronous active-high reset empties the pipeline and the queue and sets
// the spaces to RGB in and HSV out. Depends on pcc_pkg and all pcc_ modules.
`include "pixel_colorspace_converter_defines.svh"
module pixel_colorspace_converter #(
  parameter int unsigned FIFO_DEPTH = pcc_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,    // comp_a [7:0], comp_b [15:8], comp_c [23:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // res_a [7:0], res_b [15:8], res_c [23:16]
  output logic        m_tuser,    // converted
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data
);
  import pcc_pkg::*;

  logic        push;
  logic        pop;
  item_t       push_item;
  item_t       head;
  queue_stat_t q_stat;

  pcc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  pcc_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  pcc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  `PCC_ASSERT_NEVER(a_push_full, push && q_stat.full, "word pushed into a full queue")
  `PCC_ASSERT_IMPLY(a_pop_empty, pop, !q_stat.empty, "word popped from an empty queue")

endmodule
